// ----- rtl/core/ipdsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_pkg
// Shared constants, widths, register codes and control structs of the
// incremental PD speed controller.
// ----------------------------------------------------------------------------
package ipdsc_pkg;

  // Scaling limits
  localparam longint DRIVE_MAX   = 1738;
  localparam longint COMPARE_MAX = 65500;
  localparam int     SAMPLE_BITS = 12;

  // Field widths
  localparam int SP_W   = 11;
  localparam int GAIN_W = 8;
  localparam int MEAS_W = 12;
  localparam int CMP_W  = 16;
  localparam int LVL_W  = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 2'd2;
  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 8'd1;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 8'd4;

  // Input item command codes
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Arithmetic widths
  localparam int ERR_W = ((SAMPLE_BITS > SP_W) ? SAMPLE_BITS : SP_W) + 1;
  localparam int CHG_W = ERR_W + 1;
  localparam int PT_W  = ERR_W + GAIN_W + 1;
  localparam int DT_W  = CHG_W + GAIN_W + 1;
  localparam int SUM_W = DT_W + 2;
  localparam int CUR_W = LVL_W + 1;

  // Product of a scaled value and a limit, and reciprocal constants.
  // x / C is estimated as (x * floor(2^K / C)) >> K with K >= width of x;
  // the estimate is low by at most one and is fixed by one compare.
  localparam int     PROD_W    = $clog2(COMPARE_MAX * DRIVE_MAX + 1);
  localparam int     RCP_SHIFT = PROD_W;
  localparam longint RCP_CMP   = (longint'(1) << RCP_SHIFT) / COMPARE_MAX;
  localparam longint RCP_DRV   = (longint'(1) << RCP_SHIFT) / DRIVE_MAX;
  localparam int     RCP_CMP_W = $clog2(RCP_CMP + 1);
  localparam int     RCP_DRV_W = $clog2(RCP_DRV + 1);

  // Controller to datapath strobes
  typedef struct packed {
    logic load;
    logic step_err;
    logic step_est;
    logic step_fix;
    logic step_sum;
    logic step_lvl;
    logic step_est2;
    logic step_fix2;
    logic commit;
  } ipdsc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } ipdsc_status_t;

endpackage

// ----- rtl/core/ipdsc_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_item_if
// Request channel: command bit and measured speed sample.
// ----------------------------------------------------------------------------
interface ipdsc_item_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [ipdsc_pkg::MEAS_W-1:0]   measured_speed;

  modport source (output valid, output cmd, output measured_speed, input ready);
  modport sink   (input valid, input cmd, input measured_speed, output ready);
endinterface

// ----- rtl/core/ipdsc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_result_if
// Result channel: compare value, drive level and clamp flags.
// ----------------------------------------------------------------------------
interface ipdsc_result_if;
  logic                          valid;
  logic                          ready;
  logic [ipdsc_pkg::CMP_W-1:0]   compare_value;
  logic [ipdsc_pkg::LVL_W-1:0]   drive_level;
  logic                          clamped_high;
  logic                          clamped_low;

  modport source (output valid, output compare_value, output drive_level,
                  output clamped_high, output clamped_low, input ready);
  modport sink   (input valid, input compare_value, input drive_level,
                  input clamped_high, input clamped_low, output ready);
endinterface

// ----- rtl/core/ipdsc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_ctrl
// Sequencer: steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module ipdsc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_cmd,
  output logic                     in_ready,
  input  ipdsc_pkg::ipdsc_status_t status,
  output ipdsc_pkg::ipdsc_cmd_t    ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_EST    = 4'd2;
  localparam logic [3:0] S_FIX    = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_LVL    = 4'd5;
  localparam logic [3:0] S_EST2   = 4'd6;
  localparam logic [3:0] S_FIX2   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = (in_cmd == ipdsc_pkg::CMD_RESTART) ? S_LVL : S_ERR;
        end
      end
      S_ERR: begin
        ctl.step_err = 1'b1;
        state_next   = S_EST;
      end
      S_EST: begin
        ctl.step_est = 1'b1;
        state_next   = S_FIX;
      end
      S_FIX: begin
        ctl.step_fix = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        ctl.step_sum = 1'b1;
        state_next   = S_LVL;
      end
      S_LVL: begin
        ctl.step_lvl = 1'b1;
        state_next   = S_EST2;
      end
      S_EST2: begin
        ctl.step_est2 = 1'b1;
        state_next    = S_FIX2;
      end
      S_FIX2: begin
        ctl.step_fix2 = 1'b1;
        state_next    = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ERR || state == S_LVL))
    else $error("accepted request did not start the sequence");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> status.out_free)
    else $error("result committed into a full output register");

endmodule

// ----- rtl/core/ipdsc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_dp
// Datapath: config registers, error terms, constant scaling, clamp and
// output register.
// ----------------------------------------------------------------------------
module ipdsc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [ipdsc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [ipdsc_pkg::CFG_DATA_W-1:0]    wr_data,
  input  logic                                in_cmd,
  input  logic [ipdsc_pkg::MEAS_W-1:0]        in_meas,
  input  ipdsc_pkg::ipdsc_cmd_t               ctl,
  output ipdsc_pkg::ipdsc_status_t            status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ipdsc_pkg::CMP_W-1:0]         out_compare,
  output logic [ipdsc_pkg::LVL_W-1:0]         out_level,
  output logic                                out_high,
  output logic                                out_low
);

  localparam int PROD_W = ipdsc_pkg::PROD_W;
  localparam int ERR_W  = ipdsc_pkg::ERR_W;
  localparam int CHG_W  = ipdsc_pkg::CHG_W;
  localparam int SUM_W  = ipdsc_pkg::SUM_W;
  localparam int CUR_W  = ipdsc_pkg::CUR_W;
  localparam int LVL_W  = ipdsc_pkg::LVL_W;
  localparam int CMP_W  = ipdsc_pkg::CMP_W;
  localparam int SP_W   = ipdsc_pkg::SP_W;
  localparam int SB     = ipdsc_pkg::SAMPLE_BITS;
  localparam int EST_W  = PROD_W + ipdsc_pkg::RCP_CMP_W;
  localparam int EST2_W = PROD_W + ipdsc_pkg::RCP_DRV_W;

  // Config registers
  logic [SP_W-1:0]              setpoint;
  logic [ipdsc_pkg::GAIN_W-1:0] gain_p;
  logic [ipdsc_pkg::GAIN_W-1:0] gain_d;

  // Controller state held across requests
  logic signed [ERR_W-1:0] prev_error;
  logic [CMP_W-1:0]        duty;

  // Working registers
  logic                           restart;
  logic [SB-1:0]                  meas;
  logic signed [ERR_W-1:0]        err;
  logic signed [CHG_W-1:0]        chg;
  logic [PROD_W-1:0]              prod;
  logic [CUR_W-1:0]               q0;
  logic [PROD_W-1:0]              rem;
  logic signed [ipdsc_pkg::PT_W-1:0] pterm;
  logic signed [ipdsc_pkg::DT_W-1:0] dterm;
  logic signed [SUM_W-1:0]        sum;
  logic [LVL_W-1:0]               level;
  logic                           hi;
  logic                           lo;
  logic [PROD_W-1:0]              lprod;
  logic [CMP_W-1:0]               q1;
  logic [PROD_W-1:0]              rem2;

  // Combinational terms
  logic signed [ERR_W-1:0] err_next;
  logic signed [CHG_W-1:0] chg_next;
  logic [EST_W-1:0]        est_full;
  logic [EST2_W-1:0]       est2_full;
  logic [CUR_W-1:0]        cur;
  logic [LVL_W-1:0]        level_next;
  logic                    hi_next;
  logic                    lo_next;
  logic [CMP_W-1:0]        duty_next;

  assign err_next = $signed(ERR_W'(setpoint)) - $signed(ERR_W'(meas));
  assign chg_next = CHG_W'(err_next) - CHG_W'(prev_error);

  assign est_full  = EST_W'(prod) * EST_W'(ipdsc_pkg::RCP_CMP);
  assign est2_full = EST2_W'(lprod) * EST2_W'(ipdsc_pkg::RCP_DRV);

  assign cur = q0 + CUR_W'(rem >= PROD_W'(ipdsc_pkg::COMPARE_MAX));

  assign duty_next = q1 + CMP_W'(rem2 >= PROD_W'(ipdsc_pkg::DRIVE_MAX));

  always_comb begin
    level_next = '0;
    hi_next    = 1'b0;
    lo_next    = 1'b0;
    if (restart) begin
      if (SP_W'(setpoint) > SP_W'(ipdsc_pkg::DRIVE_MAX)) begin
        level_next = LVL_W'(ipdsc_pkg::DRIVE_MAX);
        hi_next    = 1'b1;
      end else begin
        level_next = LVL_W'(setpoint);
      end
    end else begin
      priority if (sum > $signed(SUM_W'(ipdsc_pkg::DRIVE_MAX))) begin
        level_next = LVL_W'(ipdsc_pkg::DRIVE_MAX);
        hi_next    = 1'b1;
      end else if (sum[SUM_W-1]) begin
        lo_next = 1'b1;
      end else begin
        level_next = sum[LVL_W-1:0];
      end
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      gain_p   <= ipdsc_pkg::GAIN_P_RESET;
      gain_d   <= ipdsc_pkg::GAIN_D_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        ipdsc_pkg::REG_SETPOINT: setpoint <= wr_data[SP_W-1:0];
        ipdsc_pkg::REG_GAIN_P:   gain_p   <= wr_data[ipdsc_pkg::GAIN_W-1:0];
        ipdsc_pkg::REG_GAIN_D:   gain_d   <= wr_data[ipdsc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      duty       <= '0;
    end else begin
      if (ctl.step_lvl && !restart) begin
        prev_error <= err;
      end
      if (ctl.commit) begin
        duty <= duty_next;
      end
    end
  end

  // Working pipeline of the sequence
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      restart <= (in_cmd == ipdsc_pkg::CMD_RESTART);
      meas    <= in_meas[SB-1:0];
    end
    if (ctl.step_err) begin
      err  <= err_next;
      chg  <= chg_next;
      prod <= PROD_W'(duty) * PROD_W'(ipdsc_pkg::DRIVE_MAX);
    end
    if (ctl.step_est) begin
      q0    <= est_full[ipdsc_pkg::RCP_SHIFT +: CUR_W];
      pterm <= err * $signed({1'b0, gain_p});
    end
    if (ctl.step_fix) begin
      rem   <= prod - PROD_W'(q0) * PROD_W'(ipdsc_pkg::COMPARE_MAX);
      dterm <= chg * $signed({1'b0, gain_d});
    end
    if (ctl.step_sum) begin
      sum <= SUM_W'(pterm) + SUM_W'(dterm) + $signed(SUM_W'(cur));
    end
    if (ctl.step_lvl) begin
      level <= level_next;
      hi    <= hi_next;
      lo    <= lo_next;
      lprod <= PROD_W'(level_next) * PROD_W'(ipdsc_pkg::COMPARE_MAX);
    end
    if (ctl.step_est2) begin
      q1 <= est2_full[ipdsc_pkg::RCP_SHIFT +: CMP_W];
    end
    if (ctl.step_fix2) begin
      rem2 <= lprod - PROD_W'(q1) * PROD_W'(ipdsc_pkg::DRIVE_MAX);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_compare <= duty_next;
      out_level   <= level;
      out_high    <= hi;
      out_low     <= lo;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level <= LVL_W'(ipdsc_pkg::DRIVE_MAX)))
    else $error("drive level above limit");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_high && out_low))
    else $error("both clamp flags set");

  a_duty_match: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> (duty == out_compare))
    else $error("stored compare value differs from result");

endmodule

// ----- rtl/core/incremental_pd_speed_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pd_speed_controller_core
// Incremental PD speed controller with clamped drive level and PWM compare
// scaling.
// ----------------------------------------------------------------------------
// Sequence: a sample request steps through error, estimate, fix, sum,
//   clamp, second estimate, second fix and commit; a restart request
//   skips straight to the clamp step. Commit waits while the output
//   register is full. The sequencer steps one shared datapath through
//   error, two reciprocal scalings and the clamp, one request at a time.
// Reset: synchronous, active high; clears previous error and compare value,
//   loads setpoint 0, gain_p 1, gain_d 4, and empties the output register.
// ----------------------------------------------------------------------------
module incremental_pd_speed_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              wr_en,
  input  logic [ipdsc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ipdsc_pkg::CFG_DATA_W-1:0]  wr_data,
  // Request and result channels
  ipdsc_item_if.sink                        item,
  ipdsc_result_if.source                    result
);

  // Strobes from the sequencer, status back from the datapath
  ipdsc_pkg::ipdsc_cmd_t    ctl;
  ipdsc_pkg::ipdsc_status_t status;

  // Sequencer: takes a request only when idle, then walks the datapath
  // through its steps; a restart request skips straight to the clamp step.
  // It holds in the commit step while the output register is still full.
  ipdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .in_ready (item.ready),
    .status   (status),
    .ctl      (ctl)
  );

  // Datapath: registers, arithmetic and the output register. The output
  // register parts the result side from the sequencer, so a new request
  // is taken while the previous result still waits downstream.
  ipdsc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_cmd      (item.cmd),
    .in_meas     (item.measured_speed),
    .ctl         (ctl),
    .status      (status),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .out_compare (result.compare_value),
    .out_level   (result.drive_level),
    .out_high    (result.clamped_high),
    .out_low     (result.clamped_low)
  );

endmodule

// ----- tb/ipdsc_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdsc_drive_checker
// Watches the register port and both channels of the PD speed controller,
// predicts each drive result from its own copy of the registers and loop
// state, and compares every returned result in order.
// ----------------------------------------------------------------------------
module ipdsc_drive_checker
  import ipdsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  ipdsc_item_if                 item,
  ipdsc_result_if               result,
  output int unsigned           fail_count,
  output int unsigned           pending,
  output int unsigned           result_count
);

  typedef struct packed {
    logic [CMP_W-1:0] compare_value;
    logic [LVL_W-1:0] drive_level;
    logic             clamped_high;
    logic             clamped_low;
  } drive_result_t;

  drive_result_t expected_drive_q[$];

  // Shadow registers and loop state
  logic [SP_W-1:0]          setpoint_r;
  logic [GAIN_W-1:0]        gain_p_r;
  logic [GAIN_W-1:0]        gain_d_r;
  logic signed [ERR_W-1:0]  last_error;
  longint                   duty_cmp;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < 40) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Advance the loop state by one request and return the drive it produces.
  task automatic advance_drive(input logic cmd, input logic [MEAS_W-1:0] meas,
                               output drive_result_t r);
    longint err;
    longint change;
    longint cur;
    longint sum;
    longint lvl;
    r = '0;
    if (cmd == CMD_RESTART) begin
      lvl = longint'(setpoint_r);
      if (lvl > DRIVE_MAX) begin
        lvl = DRIVE_MAX;
        r.clamped_high = 1'b1;
      end
    end else begin
      err    = longint'(setpoint_r) - longint'(meas);
      change = err - longint'(last_error);
      cur    = (duty_cmp * DRIVE_MAX) / COMPARE_MAX;
      sum    = err * longint'(gain_p_r) + change * longint'(gain_d_r) + cur;
      last_error = err[ERR_W-1:0];
      if (sum > DRIVE_MAX) begin
        lvl = DRIVE_MAX;
        r.clamped_high = 1'b1;
      end else if (sum < 0) begin
        lvl = 0;
        r.clamped_low = 1'b1;
      end else begin
        lvl = sum;
      end
    end
    duty_cmp        = (lvl * COMPARE_MAX) / DRIVE_MAX;
    r.compare_value = duty_cmp[CMP_W-1:0];
    r.drive_level   = lvl[LVL_W-1:0];
  endtask

  always @(posedge clk) begin : monitor
    drive_result_t want;
    if (rst) begin
      setpoint_r   = '0;
      gain_p_r     = GAIN_P_RESET;
      gain_d_r     = GAIN_D_RESET;
      last_error   = '0;
      duty_cmp     = 0;
      fail_count   = 0;
      result_count = 0;
      expected_drive_q.delete();
    end else begin
      // Check results first so a result can never match a request of the same edge
      if (result.valid && result.ready) begin
        result_count++;
        if (expected_drive_q.size() == 0) begin
          report_mismatch("result with nothing expected, drive_level",
                          longint'(result.drive_level), longint'(0));
        end else begin
          want = expected_drive_q.pop_front();
          if (result.compare_value !== want.compare_value)
            report_mismatch("compare_value", longint'(result.compare_value),
                            longint'(want.compare_value));
          if (result.drive_level !== want.drive_level)
            report_mismatch("drive_level", longint'(result.drive_level),
                            longint'(want.drive_level));
          if (result.clamped_high !== want.clamped_high)
            report_mismatch("clamped_high", longint'(result.clamped_high),
                            longint'(want.clamped_high));
          if (result.clamped_low !== want.clamped_low)
            report_mismatch("clamped_low", longint'(result.clamped_low),
                            longint'(want.clamped_low));
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_SETPOINT: setpoint_r = wr_data[SP_W-1:0];
          REG_GAIN_P:   gain_p_r   = wr_data[GAIN_W-1:0];
          REG_GAIN_D:   gain_d_r   = wr_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        advance_drive(item.cmd, item.measured_speed, want);
        expected_drive_q.push_back(want);
      end
    end
    pending = expected_drive_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the incremental PD speed controller with directed corner requests
// and several hundred random ones across many gain and setpoint settings,
// with random gaps on both channels and one long result stall; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import ipdsc_pkg::*;

  localparam int unsigned IDLE_PCT      = 11;    // percent of cycles a side idles
  localparam int unsigned LAT_GUARD     = 12;    // cycles to let the sequencer settle
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver stall
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 62;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ipdsc_item_if   item_ch();
  ipdsc_result_if result_ch();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;

  // Stimulus bookkeeping
  bit              idle_on;
  int unsigned     hold_off_len;
  int unsigned     n_requests;
  int unsigned     n_restarts;
  int unsigned     n_settings;
  logic [SP_W-1:0] cur_sp;

  incremental_pd_speed_controller_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  ipdsc_drive_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .item         (item_ch),
    .result       (result_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Timed out waiting for the controller to drain");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result sink: drop ready at random, and hold it low for a long stretch when
  // the stimulus asks, so the block backs up and stalls its request side.
  initial begin : result_sink
    int unsigned hold;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        hold         = hold_off_len;
        hold_off_len = 0;
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= !(idle_on && ($urandom_range(0, 99) < IDLE_PCT));
    end
  end

  // Offer one request and hold it until the block takes it. Valid is left high
  // on return so back-to-back requests keep valid high without a gap.
  task automatic send_request(input logic cmd, input logic [MEAS_W-1:0] meas);
    while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.cmd            <= cmd;
    item_ch.measured_speed <= meas;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    n_requests++;
    if (cmd == CMD_RESTART) n_restarts++;
  endtask

  // Drop valid and wait until every expected result is back, plus a margin.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram all three registers once the block has gone idle.
  task automatic load_settings(input logic [SP_W-1:0] sp, input logic [GAIN_W-1:0] gp,
                               input logic [GAIN_W-1:0] gd);
    settle();
    write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
    write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    cur_sp = sp;
    n_settings++;
  endtask

  // Favor the full range ends, then the in-range values.
  function automatic logic [SP_W-1:0] pick_setpoint();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SP_W'(DRIVE_MAX);
      default: return SP_W'($urandom_range(0, (1 << SP_W) - 1));
    endcase
  endfunction

  // Small gains keep the loop out of saturation; the ends still show up.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 6));
    endcase
  endfunction

  // Mostly samples near the setpoint so the level settles inside its range.
  function automatic logic [MEAS_W-1:0] pick_sample();
    int m;
    if ($urandom_range(0, 9) < 3) return MEAS_W'($urandom);
    m = int'(cur_sp) + int'($urandom_range(0, 64)) - 32;
    if (m < 0) m = 0;
    if (m > (1 << MEAS_W) - 1) m = (1 << MEAS_W) - 1;
    return MEAS_W'(m);
  endfunction

  initial begin : stimulus
    int unsigned drain_cycles;
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_index               = REG_SETPOINT;
    wr_data                = '0;
    item_ch.valid          = 1'b0;
    item_ch.cmd            = CMD_SAMPLE;
    item_ch.measured_speed = '0;
    idle_on                = 1'b1;
    hold_off_len           = 0;
    n_requests             = 0;
    n_restarts             = 0;
    n_settings             = 1;
    cur_sp                 = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: zero error, a sample far above the setpoint, a restart
    send_request(CMD_SAMPLE, '0);
    send_request(CMD_SAMPLE, '1);
    send_request(CMD_RESTART, '1);

    // Top setpoint and gains: restart saturates high, samples swing both ways
    load_settings('1, '1, '1);
    send_request(CMD_RESTART, '0);
    send_request(CMD_SAMPLE, '0);
    send_request(CMD_SAMPLE, '1);
    send_request(CMD_SAMPLE, MEAS_W'(2047));

    // Setpoint exactly at the limit with zero gains: full compare, no clamp
    load_settings(SP_W'(DRIVE_MAX), '0, '0);
    send_request(CMD_RESTART, MEAS_W'(12'h5A5));
    send_request(CMD_SAMPLE, MEAS_W'(1234));
    send_request(CMD_SAMPLE, '1);

    // Proportional only, single-step moves and alternating bit patterns
    load_settings(SP_W'(900), GAIN_W'(1), '0);
    send_request(CMD_SAMPLE, MEAS_W'(900));
    send_request(CMD_SAMPLE, MEAS_W'(899));
    send_request(CMD_SAMPLE, MEAS_W'(12'hAAA));
    send_request(CMD_SAMPLE, MEAS_W'(12'h555));

    // Setpoint just past the limit: restart clamps, the sample gives zero error
    load_settings(SP_W'(DRIVE_MAX + 1), GAIN_W'(1), GAIN_W'(1));
    send_request(CMD_RESTART, '0);
    send_request(CMD_SAMPLE, MEAS_W'(DRIVE_MAX + 1));

    // Zero setpoint with a big gain: a sample just above it pulls the level down
    load_settings('0, '1, '0);
    send_request(CMD_SAMPLE, MEAS_W'(1));

    // Random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_settings(pick_setpoint(), pick_gain(), pick_gain());
      idle_on = (ph != 3);                      // one phase runs flat out
      if (ph == 5) hold_off_len = HOLD_CYCLES;  // back up the result side once
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) send_request(CMD_RESTART, MEAS_W'($urandom));
        else send_request(CMD_SAMPLE, pick_sample());
      end
    end

    // Drain: wait for outstanding results, bounded, then a latency margin
    idle_on = 1'b1;
    item_ch.valid <= 1'b0;
    drain_cycles = 0;
    @(posedge clk);
    while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (LAT_GUARD) @(posedge clk);

    $display("Run covered %0d requests (%0d restarts) over %0d register settings, %0d results",
             n_requests, n_restarts, n_settings, result_count);
    $display("Included gain and setpoint extremes, clamps both ways and a %0d-cycle result stall",
             HOLD_CYCLES);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
